>>> hdl/bmd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmd_pkg
// Shared types and constants of the 2x2 box-filter mip downsampler.
// ----------------------------------------------------------------------------
package bmd_pkg;

    localparam int CFG_W     = 13;  // width of the size registers
    localparam int CFG_IDX_W = 1;   // register index width
    localparam int NUM_CH    = 4;   // RGBA
    localparam int CH_W      = 8;   // bits per channel
    localparam int PAIR_W    = CH_W + 1;  // sum of two channel bytes
    localparam int SUM_W     = CH_W + 2;  // sum of four channel bytes

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SRC_WIDTH  = 1'b0,
        REG_SRC_HEIGHT = 1'b1
    } t_cfg_reg;

    typedef logic [NUM_CH-1:0][CH_W-1:0]   t_pixel;
    typedef logic [NUM_CH-1:0][PAIR_W-1:0] t_pair;

endpackage

>>> hdl/bmd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmd_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bmd_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 2048,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hdl/box_filter_mip_downsample.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_filter_mip_downsample
// Streaming 2x2 box filter that turns one RGBA8 mip level into the next.
// ----------------------------------------------------------------------------
// Usage:
//   Source pixels enter on the pix channel (i_pix_valid / o_pix_ready), one
//   transaction per pixel, in raster order. Each channel of a destination
//   pixel is (sum of the 2x2 block + 2) >> 2 and leaves on the out channel
//   (o_out_valid / i_out_ready); o_out_last marks the final pixel of a level.
//   An odd last column or row is dropped; a source dimension of 1 pairs each
//   pixel with itself along that axis. After the last source pixel the
//   position wraps, so the next pixel starts a new level of the same size.
//   Write src_width / src_height through the cfg port while idle; any write
//   restarts the level. Out-of-range sizes are clamped (0 acts as 1).
// Timing:
//   One pixel per cycle sustained while the receiver accepts. The result
//   for the pixel completing a block passes the line-store read, then the
//   output register. The line store keeps one 36-bit row of pair sums
//   (four 9-bit sums per destination column) in a one-read, one-write RAM.
// Reset and stall:
//   Synchronous reset clears the position, held pixel, sizes (1 x 1) and the
//   pipeline; the line store is not cleared, every entry is written in an
//   even row before an odd row reads it. When the receiver stalls, the
//   output register and the read stage fill and then o_pix_ready drops.
// ----------------------------------------------------------------------------
module box_filter_mip_downsample
    import bmd_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_wr_data,
    // source pixels
    input  logic                 i_pix_valid,
    output logic                 o_pix_ready,
    input  logic [CH_W-1:0]      i_pix_c0,
    input  logic [CH_W-1:0]      i_pix_c1,
    input  logic [CH_W-1:0]      i_pix_c2,
    input  logic [CH_W-1:0]      i_pix_c3,
    // destination pixels
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [CH_W-1:0]      o_out_c0,
    output logic [CH_W-1:0]      o_out_c1,
    output logic [CH_W-1:0]      o_out_c2,
    output logic [CH_W-1:0]      o_out_c3,
    output logic                 o_out_last
);

    localparam int XW         = (MAX_WIDTH > 1)  ? $clog2(MAX_WIDTH)  : 1;
    localparam int YW         = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WDW        = $clog2(MAX_WIDTH + 1);
    localparam int HDW        = $clog2(MAX_HEIGHT + 1);
    localparam int WCW        = (WDW > CFG_W) ? WDW : CFG_W;
    localparam int HCW        = (HDW > CFG_W) ? HDW : CFG_W;
    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int LW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

    // ------------------------------------------------------------------
    // Size registers, kept in the form the datapath compares against:
    // "dimension is one" and the last position that still belongs to a
    // full 2x2 block (2*d - 1).
    // ------------------------------------------------------------------
    logic          r_w_one, n_w_one;
    logic          r_h_one, n_h_one;
    logic [XW-1:0] r_x_keep_max, n_x_keep_max;
    logic [YW-1:0] r_y_keep_max, n_y_keep_max;
    logic [XW-1:0] r_x_end, n_x_end;    // w - 1
    logic [YW-1:0] r_y_end, n_y_end;    // h - 1

    logic [WCW-1:0] cfg_w_ext;
    logic [HCW-1:0] cfg_h_ext;
    logic [WDW-1:0] cfg_w;
    logic [HDW-1:0] cfg_h;

    always_comb begin
        cfg_w_ext = WCW'(i_cfg_wr_data);
        cfg_h_ext = HCW'(i_cfg_wr_data);
        // clamp into 1 .. MAX
        if (cfg_w_ext == '0) begin
            cfg_w = WDW'(1);
        end else if (cfg_w_ext > WCW'(MAX_WIDTH)) begin
            cfg_w = WDW'(MAX_WIDTH);
        end else begin
            cfg_w = WDW'(cfg_w_ext);
        end
        if (cfg_h_ext == '0) begin
            cfg_h = HDW'(1);
        end else if (cfg_h_ext > HCW'(MAX_HEIGHT)) begin
            cfg_h = HDW'(MAX_HEIGHT);
        end else begin
            cfg_h = HDW'(cfg_h_ext);
        end

        n_w_one      = r_w_one;
        n_h_one      = r_h_one;
        n_x_keep_max = r_x_keep_max;
        n_y_keep_max = r_y_keep_max;
        n_x_end      = r_x_end;
        n_y_end      = r_y_end;
        if (i_cfg_wr_en) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_SRC_WIDTH: begin
                    n_w_one      = (cfg_w == WDW'(1));
                    n_x_keep_max = XW'((cfg_w & ~WDW'(1)) - WDW'(1));
                    n_x_end      = XW'(cfg_w - WDW'(1));
                end
                REG_SRC_HEIGHT: begin
                    n_h_one      = (cfg_h == HDW'(1));
                    n_y_keep_max = YW'((cfg_h & ~HDW'(1)) - HDW'(1));
                    n_y_end      = YW'(cfg_h - HDW'(1));
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_one      <= 1'b1;
            r_h_one      <= 1'b1;
            r_x_keep_max <= '0;
            r_y_keep_max <= '0;
            r_x_end      <= '0;
            r_y_end      <= '0;
        end else begin
            r_w_one      <= n_w_one;
            r_h_one      <= n_h_one;
            r_x_keep_max <= n_x_keep_max;
            r_y_keep_max <= n_y_keep_max;
            r_x_end      <= n_x_end;
            r_y_end      <= n_y_end;
        end
    end

    // ------------------------------------------------------------------
    // Handshake and pipeline control
    // ------------------------------------------------------------------
    logic r_s1_valid;
    logic r_o_valid;
    logic out_free;
    logic pix_acc;

    assign out_free    = !r_o_valid || i_out_ready;
    assign o_pix_ready = !r_s1_valid || out_free;
    assign pix_acc     = i_pix_valid && o_pix_ready;

    // ------------------------------------------------------------------
    // Stage 0: horizontal pairing, line-store write or read
    // ------------------------------------------------------------------
    logic [XW-1:0] r_x, n_x;
    logic [YW-1:0] r_y, n_y;
    t_pixel        r_held;
    t_pixel        pix;
    t_pair         pair;
    logic          x_keep, y_keep;
    logic          have_pair, hold_pix, line_wr, emit, is_last;
    logic [LW-1:0] line_idx;

    assign pix = {i_pix_c3, i_pix_c2, i_pix_c1, i_pix_c0};

    always_comb begin
        x_keep    = (r_x <= r_x_keep_max);
        y_keep    = (r_y <= r_y_keep_max);
        have_pair = r_w_one || (x_keep && r_x[0]);
        hold_pix  = !r_w_one && x_keep && !r_x[0];
        line_wr   = have_pair && !r_h_one && y_keep && !r_y[0];
        emit      = have_pair && (r_h_one || (y_keep && r_y[0]));
        is_last   = (r_w_one || (r_x == r_x_keep_max))
                 && (r_h_one || (r_y == r_y_keep_max));
        line_idx  = r_w_one ? '0 : LW'(r_x >> 1);
        for (int c = 0; c < NUM_CH; c++) begin
            if (r_w_one) begin
                pair[c] = {pix[c], 1'b0};
            end else begin
                pair[c] = PAIR_W'(r_held[c]) + PAIR_W'(pix[c]);
            end
        end
        // advance raster position, wrap at end of row and end of level
        if (r_x == r_x_end) begin
            n_x = '0;
            n_y = (r_y == r_y_end) ? '0 : r_y + YW'(1);
        end else begin
            n_x = r_x + XW'(1);
            n_y = r_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_wr_en) begin
            r_x    <= '0;
            r_y    <= '0;
            r_held <= '0;
        end else if (pix_acc) begin
            r_x <= n_x;
            r_y <= n_y;
            if (hold_pix) begin
                r_held <= pix;
            end
        end
    end

    // Pair-sum line store. A write lands in an even row and the matching
    // read comes from the next row, in a later pixel transaction, so the
    // read always sees the written data.
    t_pair line_rd;

    bmd_ram #(
        .WIDTH ($bits(t_pair)),
        .DEPTH (LINE_DEPTH)
    ) u_line (
        .i_clk     (i_clk),
        .i_wr_en   (pix_acc && line_wr),
        .i_wr_addr (line_idx),
        .i_wr_data (pair),
        .i_rd_en   (pix_acc && emit),
        .i_rd_addr (line_idx),
        .o_rd_data (line_rd)
    );

    // ------------------------------------------------------------------
    // Stage 1: vertical sum and rounding. RAM read data holds while the
    // stage stalls because no new read is issued.
    // ------------------------------------------------------------------
    t_pair r_s1_pair;
    logic  r_s1_self;
    logic  r_s1_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (pix_acc) begin
            r_s1_valid <= emit;
        end else if (out_free) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_acc && emit) begin
            r_s1_pair <= pair;
            r_s1_self <= r_h_one;
            r_s1_last <= is_last;
        end
    end

    t_pixel         avg;
    logic [SUM_W-1:0] sum [NUM_CH];

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            if (r_s1_self) begin
                sum[c] = {r_s1_pair[c], 1'b0};
            end else begin
                sum[c] = SUM_W'(line_rd[c]) + SUM_W'(r_s1_pair[c]);
            end
            avg[c] = CH_W'((sum[c] + SUM_W'(2)) >> 2);
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    t_pixel r_o_pix;
    logic   r_o_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_free) begin
            r_o_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_s1_valid) begin
            r_o_pix  <= avg;
            r_o_last <= r_s1_last;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_c0    = r_o_pix[0];
    assign o_out_c1    = r_o_pix[1];
    assign o_out_c2    = r_o_pix[2];
    assign o_out_c3    = r_o_pix[3];
    assign o_out_last  = r_o_last;

endmodule

>>> hdl/bmd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmd_checker
// Port-level assertions for the box-filter mip downsampler.
// ----------------------------------------------------------------------------
module bmd_checker
    import bmd_pkg::*;
(
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            o_pix_ready,
    input logic            o_out_valid,
    input logic            i_out_ready,
    input logic [CH_W-1:0] o_out_c0,
    input logic [CH_W-1:0] o_out_c1,
    input logic [CH_W-1:0] o_out_c2,
    input logic [CH_W-1:0] o_out_c3,
    input logic            o_out_last
);

    // Reset empties the pipeline.
    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // With no result pending the block must take a pixel.
    a_empty_ready : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_pix_ready)
        else $error("input stalled with empty output");

    // After reset the input side is open.
    a_reset_ready : assert property (@(posedge i_clk)
        !i_rst_n |=> o_pix_ready)
        else $error("input not ready after reset");

    // A stalled result holds.
    a_out_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid
            && $stable(o_out_c0) && $stable(o_out_c1)
            && $stable(o_out_c2) && $stable(o_out_c3) && $stable(o_out_last))
        else $error("stalled result changed");

endmodule

bind box_filter_mip_downsample bmd_checker u_bmd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_pix_ready (o_pix_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_c0    (o_out_c0),
    .o_out_c1    (o_out_c1),
    .o_out_c2    (o_out_c2),
    .o_out_c3    (o_out_c3),
    .o_out_last  (o_out_last)
);
